FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: sv/bsm_pkg.sv
// ----------------------------------------------------------------------------
// Battery status monitor package
// Widths, state codes, register indexes, reset values and divide constants.
// ----------------------------------------------------------------------------
package bsm_pkg;

   localparam int HISTORY_DEPTH = 30;
   localparam int HIST_PTR_W    = $clog2(HISTORY_DEPTH);

   localparam int TIME_W     = 32;
   localparam int MV_W       = 13;
   localparam int PCT_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int STATE_W    = 3;

   typedef logic [STATE_W-1:0] state_type;
   typedef logic [MV_W-1:0]    mv_type;
   typedef logic [TIME_W-1:0]  time_type;

   localparam state_type MON_UNKNOWN  = 3'd0;
   localparam state_type MON_BATTERY  = 3'd1;
   localparam state_type MON_CHARGING = 3'd2;
   localparam state_type MON_FULL     = 3'd3;
   localparam state_type MON_LOW      = 3'd4;
   localparam state_type MON_CRITICAL = 3'd5;
   localparam state_type MON_USB      = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_PCT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_MV      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MV           = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK_MV      = 3'd6;

   localparam logic [15:0]     RST_SAMPLE_INTERVAL  = 16'd2000;
   localparam logic [19:0]     RST_HISTORY_INTERVAL = 20'd20000;
   localparam mv_type          RST_FULL_MV          = 13'd4100;
   localparam logic [6:0]      RST_FULL_PCT         = 7'd99;
   localparam mv_type          RST_CRITICAL_MV      = 13'd3300;
   localparam mv_type          RST_LOW_MV           = 13'd3500;
   localparam mv_type          RST_FALLBACK_MV      = 13'd3300;

   localparam logic [6:0]      PCT_MAX = 7'd100;

   // divide by 10 and by 9 as multiply and shift, exact for 14-bit operands
   localparam int          RECIP_SHIFT = 19;
   localparam logic [15:0] DIV10_MUL   = 16'd52429;
   localparam logic [15:0] DIV9_MUL    = 16'd58255;

   // divide by 60000: drop 5 bits, then divide by 1875, exact for 27 bits
   localparam int          MIN_PRESHIFT = 5;
   localparam int          MIN_SHIFT    = 38;
   localparam logic [27:0] MIN_MUL      = 28'd146601551;

endpackage

FILE: sv/battery_status_monitor_core.sv
// ----------------------------------------------------------------------------
// Battery status monitor core
// Samples power readings on an interval, keeps a voltage history ring,
// classifies the battery state and tracks the current charge.
// ----------------------------------------------------------------------------
// Takes one item per clock unless a low rsp_ready stalls it, and returns one
// result item for each: the item is captured in an input register, all sampling,
// history, classification and output arithmetic is done in one pass from that
// register and the state registers, and the result lands in an output register
// that holds while rsp_ready is low. The sustained rate of one item per clock
// is set by the single-pass update of the state registers. The history ring is
// a bank of HISTORY_DEPTH registers; trend reads zero until it has been filled.
module battery_status_monitor_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bsm_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                           req_battery_present,
   input  logic [bsm_pkg::MV_W-1:0]       req_batt_mv,
   input  logic signed [bsm_pkg::PCT_W-1:0] req_gauge_pct,
   input  logic                           req_vbus_present,
   input  logic                           req_is_charging,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_sampled,
   output logic [2:0]                     rsp_state_code,
   output logic                           rsp_state_changed,
   output logic [12:0]                    rsp_battery_mv,
   output logic [6:0]                     rsp_percent,
   output logic signed [10:0]             rsp_trend_mv_per_min,
   output logic signed [13:0]             rsp_since_charge_mv,
   output logic [16:0]                    rsp_charge_minutes,
   input  logic                           csr_we,
   input  logic [bsm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bsm_pkg::*;

   `include "assert_macros.svh"

   // configuration
   logic [15:0]     sample_int_ff;
   logic [19:0]     hist_int_ff;
   mv_type          full_mv_ff;
   logic [6:0]      full_pct_ff;
   mv_type          critical_mv_ff;
   mv_type          low_mv_ff;
   mv_type          fallback_mv_ff;

   // input register
   logic            s1_valid_ff;
   time_type        s1_now_ff;
   logic            s1_bat_ff;
   mv_type          s1_mv_ff;
   logic [PCT_W-1:0] s1_pct_ff;
   logic            s1_vbus_ff;
   logic            s1_chg_ff;
   logic            s1_adv;

   // monitor state
   state_type       cur_state_ff, cur_state_in;
   mv_type          latched_mv_ff, latched_mv_in;
   logic [PCT_W-1:0] latched_pct_ff, latched_pct_in;
   time_type        last_sample_ff, last_sample_in;
   time_type        last_hist_ff, last_hist_in;
   mv_type          ring_ff [HISTORY_DEPTH];
   logic [HIST_PTR_W-1:0] hist_pos_ff, hist_pos_in;
   logic            hist_full_ff, hist_full_in;
   logic            chg_active_ff, chg_active_in;
   time_type        chg_time_ff, chg_time_in;
   mv_type          chg_mv_ff, chg_mv_in;
   logic            hist_push;

   // result register
   logic            rsp_valid_ff;
   logic            rsp_sampled_ff, rsp_sampled_in;
   state_type       rsp_state_ff;
   logic            rsp_changed_ff, rsp_changed_in;
   mv_type          rsp_mv_ff;
   logic [6:0]      rsp_pct_ff, rsp_pct_in;
   logic [10:0]     rsp_trend_ff, rsp_trend_in;
   logic [13:0]     rsp_since_ff, rsp_since_in;
   logic [16:0]     rsp_minutes_ff, rsp_minutes_in;

   // pass logic
   time_type        sample_gap;
   time_type        hist_gap;
   logic            do_sample;
   state_type       class_state;
   logic            full_hit;
   mv_type          oldest_mv;
   logic [13:0]     diff_mv;
   logic [12:0]     diff_mag;
   logic [28:0]     trend_prod;
   logic [9:0]      trend_q;
   mv_type          fb_delta;
   logic [28:0]     fb_prod;
   logic [9:0]      fb_q;
   time_type        chg_gap;
   logic [TIME_W-MIN_PRESHIFT-1:0] chg_gap_sh;
   logic [54:0]     min_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_int_ff  <= RST_SAMPLE_INTERVAL;
         hist_int_ff    <= RST_HISTORY_INTERVAL;
         full_mv_ff     <= RST_FULL_MV;
         full_pct_ff    <= RST_FULL_PCT;
         critical_mv_ff <= RST_CRITICAL_MV;
         low_mv_ff      <= RST_LOW_MV;
         fallback_mv_ff <= RST_FALLBACK_MV;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL:  sample_int_ff  <= csr_wdata[15:0];
            CSR_HISTORY_INTERVAL: hist_int_ff    <= csr_wdata;
            CSR_FULL_MV:          full_mv_ff     <= csr_wdata[MV_W-1:0];
            CSR_FULL_PCT:         full_pct_ff    <= csr_wdata[6:0];
            CSR_CRITICAL_MV:      critical_mv_ff <= csr_wdata[MV_W-1:0];
            CSR_LOW_MV:           low_mv_ff      <= csr_wdata[MV_W-1:0];
            CSR_FALLBACK_MV:      fallback_mv_ff <= csr_wdata[MV_W-1:0];
            default: ;
         endcase
      end
   end

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_now_ff  <= req_now_ms;
         s1_bat_ff  <= req_battery_present;
         s1_mv_ff   <= req_batt_mv;
         s1_pct_ff  <= req_gauge_pct;
         s1_vbus_ff <= req_vbus_present;
         s1_chg_ff  <= req_is_charging;
      end
   end

   always_comb begin
      sample_gap = s1_now_ff - last_sample_ff;
      hist_gap   = s1_now_ff - last_hist_ff;
      do_sample  = sample_gap >= {16'd0, sample_int_ff};

      latched_mv_in  = latched_mv_ff;
      latched_pct_in = latched_pct_ff;
      last_sample_in = last_sample_ff;
      if (do_sample) begin
         last_sample_in = s1_now_ff;
         latched_mv_in  = s1_bat_ff ? s1_mv_ff : '0;
         latched_pct_in = s1_bat_ff ? s1_pct_ff : '1;
      end

      hist_push    = do_sample && (hist_gap >= {12'd0, hist_int_ff});
      last_hist_in = hist_push ? s1_now_ff : last_hist_ff;
      hist_pos_in  = hist_pos_ff;
      hist_full_in = hist_full_ff;
      if (hist_push) begin
         if (hist_pos_ff == HIST_PTR_W'(HISTORY_DEPTH - 1)) begin
            hist_pos_in  = '0;
            hist_full_in = 1'b1;
         end else begin
            hist_pos_in = hist_pos_ff + 1'b1;
         end
      end

      full_hit = (latched_mv_in >= full_mv_ff) ||
                 ($signed(latched_pct_in) >= $signed({1'b0, full_pct_ff}));
      if (!s1_bat_ff) begin
         class_state = MON_UNKNOWN;
      end else if (s1_vbus_ff) begin
         if (s1_chg_ff) begin
            class_state = MON_CHARGING;
         end else if (full_hit) begin
            class_state = MON_FULL;
         end else begin
            class_state = MON_USB;
         end
      end else if (latched_mv_in <= critical_mv_ff) begin
         class_state = MON_CRITICAL;
      end else if (latched_mv_in <= low_mv_ff) begin
         class_state = MON_LOW;
      end else begin
         class_state = MON_BATTERY;
      end

      rsp_sampled_in = do_sample;
      rsp_changed_in = do_sample && (class_state != cur_state_ff);
      cur_state_in   = rsp_changed_in ? class_state : cur_state_ff;

      chg_active_in = chg_active_ff;
      chg_time_in   = chg_time_ff;
      chg_mv_in     = chg_mv_ff;
      if (rsp_changed_in) begin
         if (class_state == MON_CHARGING) begin
            chg_active_in = 1'b1;
            chg_time_in   = s1_now_ff;
            chg_mv_in     = latched_mv_in;
         end else if (class_state != MON_FULL) begin
            chg_active_in = 1'b0;
         end
      end

      // oldest entry sits at the next write position
      oldest_mv  = ring_ff[hist_pos_in];
      diff_mv    = {1'b0, latched_mv_in} - {1'b0, oldest_mv};
      diff_mag   = diff_mv[13] ? 13'(-diff_mv) : diff_mv[12:0];
      trend_prod = {16'd0, diff_mag} * {13'd0, DIV10_MUL};
      trend_q    = trend_prod[RECIP_SHIFT +: 10];
      if (!hist_full_in) begin
         rsp_trend_in = '0;
      end else if (diff_mv[13]) begin
         rsp_trend_in = 11'(-{1'b0, trend_q});
      end else begin
         rsp_trend_in = {1'b0, trend_q};
      end

      fb_delta = latched_mv_in - fallback_mv_ff;
      fb_prod  = {16'd0, fb_delta} * {13'd0, DIV9_MUL};
      fb_q     = fb_prod[RECIP_SHIFT +: 10];
      if (!latched_pct_in[PCT_W-1]) begin
         rsp_pct_in = (latched_pct_in[6:0] > PCT_MAX) ? PCT_MAX : latched_pct_in[6:0];
      end else if (latched_mv_in <= fallback_mv_ff) begin
         rsp_pct_in = '0;
      end else if (fb_q > {3'd0, PCT_MAX}) begin
         rsp_pct_in = PCT_MAX;
      end else begin
         rsp_pct_in = fb_q[6:0];
      end

      chg_gap    = s1_now_ff - chg_time_in;
      chg_gap_sh = chg_gap[TIME_W-1:MIN_PRESHIFT];
      min_prod   = {28'd0, chg_gap_sh} * {27'd0, MIN_MUL};
      if (chg_active_in) begin
         rsp_since_in   = {1'b0, latched_mv_in} - {1'b0, chg_mv_in};
         rsp_minutes_in = min_prod[MIN_SHIFT +: 17];
      end else begin
         rsp_since_in   = '0;
         rsp_minutes_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff   <= MON_UNKNOWN;
         latched_mv_ff  <= '0;
         latched_pct_ff <= '1;
         last_sample_ff <= '0;
         last_hist_ff   <= '0;
         hist_pos_ff    <= '0;
         hist_full_ff   <= 1'b0;
         chg_active_ff  <= 1'b0;
         chg_time_ff    <= '0;
         chg_mv_ff      <= '0;
      end else if (s1_adv) begin
         cur_state_ff   <= cur_state_in;
         latched_mv_ff  <= latched_mv_in;
         latched_pct_ff <= latched_pct_in;
         last_sample_ff <= last_sample_in;
         last_hist_ff   <= last_hist_in;
         hist_pos_ff    <= hist_pos_in;
         hist_full_ff   <= hist_full_in;
         chg_active_ff  <= chg_active_in;
         chg_time_ff    <= chg_time_in;
         chg_mv_ff      <= chg_mv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && hist_push) begin
         ring_ff[hist_pos_ff] <= latched_mv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_sampled_ff <= rsp_sampled_in;
         rsp_state_ff   <= cur_state_in;
         rsp_changed_ff <= rsp_changed_in;
         rsp_mv_ff      <= latched_mv_in;
         rsp_pct_ff     <= rsp_pct_in;
         rsp_trend_ff   <= rsp_trend_in;
         rsp_since_ff   <= rsp_since_in;
         rsp_minutes_ff <= rsp_minutes_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sampled          = rsp_sampled_ff;
   assign rsp_state_code       = rsp_state_ff;
   assign rsp_state_changed    = rsp_changed_ff;
   assign rsp_battery_mv       = rsp_mv_ff;
   assign rsp_percent          = rsp_pct_ff;
   assign rsp_trend_mv_per_min = rsp_trend_ff;
   assign rsp_since_charge_mv  = rsp_since_ff;
   assign rsp_charge_minutes   = rsp_minutes_ff;

   `ASSERT_IMPLIES(a_changed_needs_sample, clock, reset, rsp_valid_ff && rsp_changed_ff, rsp_sampled_ff)
   `ASSERT_IMPLIES(a_charging_has_record, clock, reset, cur_state_ff == MON_CHARGING, chg_active_ff)
   `ASSERT_IMPLIES(a_pct_in_range, clock, reset, rsp_valid_ff, rsp_pct_ff <= PCT_MAX)
   `ASSERT_IMPLIES(a_hist_pos_range, clock, reset, 1'b1, hist_pos_ff <= HIST_PTR_W'(HISTORY_DEPTH - 1))
   `ASSERT_NEXT(a_advance_fills_rsp, clock, reset, s1_adv, rsp_valid_ff)

endmodule

FILE: dv/bsm_poll_checker.sv
// ----------------------------------------------------------------------------
// Battery status monitor poll checker
// Watches the poll, result and register ports of the monitor core, keeps its
// own copy of the sampling, history, classification and charge-record state,
// predicts one result item per accepted poll and compares result items in
// order, field by field.
// ----------------------------------------------------------------------------
module bsm_poll_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [bsm_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                           req_battery_present,
   input  logic [bsm_pkg::MV_W-1:0]       req_batt_mv,
   input  logic signed [bsm_pkg::PCT_W-1:0] req_gauge_pct,
   input  logic                           req_vbus_present,
   input  logic                           req_is_charging,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_sampled,
   input  logic [2:0]                     rsp_state_code,
   input  logic                           rsp_state_changed,
   input  logic [12:0]                    rsp_battery_mv,
   input  logic [6:0]                     rsp_percent,
   input  logic signed [10:0]             rsp_trend_mv_per_min,
   input  logic signed [13:0]             rsp_since_charge_mv,
   input  logic [16:0]                    rsp_charge_minutes,
   input  logic                           csr_we,
   input  logic [bsm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             error_count,
   output int                             reports_pending
);
   import bsm_pkg::*;

   typedef struct packed {
      logic               sampled;
      state_type          state_code;
      logic               state_changed;
      mv_type             battery_mv;
      logic [6:0]         percent;
      logic signed [10:0] trend;
      logic signed [13:0] since_mv;
      logic [16:0]        minutes;
   } poll_report_type;

   logic [15:0] sample_iv;
   logic [19:0] history_iv;
   mv_type      full_mv_th;
   logic [6:0]  full_pct_th;
   mv_type      critical_mv_th;
   mv_type      low_mv_th;
   mv_type      empty_mv;

   state_type         cur_state;
   mv_type            held_mv;
   logic signed [7:0] held_pct;
   time_type          last_sample;
   time_type          last_push;
   mv_type            volt_ring [HISTORY_DEPTH];
   int                ring_fill;
   int                ring_pos;
   logic              charge_tracked;
   time_type          charge_t0;
   mv_type            charge_mv0;

   poll_report_type awaited_reports [$];

   task automatic clear_model();
      sample_iv      = RST_SAMPLE_INTERVAL;
      history_iv     = RST_HISTORY_INTERVAL;
      full_mv_th     = RST_FULL_MV;
      full_pct_th    = RST_FULL_PCT;
      critical_mv_th = RST_CRITICAL_MV;
      low_mv_th      = RST_LOW_MV;
      empty_mv       = RST_FALLBACK_MV;
      cur_state      = MON_UNKNOWN;
      held_mv        = '0;
      held_pct       = -8'sd1;
      last_sample    = '0;
      last_push      = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) volt_ring[i] = '0;
      ring_fill      = 0;
      ring_pos       = 0;
      charge_tracked = 1'b0;
      charge_t0      = '0;
      charge_mv0     = '0;
   endtask

   task automatic take_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SAMPLE_INTERVAL:  sample_iv      = val[15:0];
         CSR_HISTORY_INTERVAL: history_iv     = val[19:0];
         CSR_FULL_MV:          full_mv_th     = val[MV_W-1:0];
         CSR_FULL_PCT:         full_pct_th    = val[6:0];
         CSR_CRITICAL_MV:      critical_mv_th = val[MV_W-1:0];
         CSR_LOW_MV:           low_mv_th      = val[MV_W-1:0];
         CSR_FALLBACK_MV:      empty_mv       = val[MV_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [6:0] shown_percent();
      int v;
      if (held_pct >= 0) return (held_pct > 100) ? PCT_MAX : held_pct[6:0];
      if (held_mv <= empty_mv) return 7'd0;
      v = (int'(held_mv) - int'(empty_mv)) * 100 / 900;
      return (v > 100) ? PCT_MAX : v[6:0];
   endfunction

   task automatic predict_poll(input time_type now, input logic bat, input mv_type mv,
                               input logic signed [7:0] gauge, input logic vbus,
                               input logic chg, output poll_report_type rep);
      state_type next_state;
      int        trend_v;
      int        since_v;
      time_type  elapsed;
      rep = '0;
      if (now - last_sample >= 32'(sample_iv)) begin
         rep.sampled = 1'b1;
         last_sample = now;
         held_mv     = bat ? mv : '0;
         held_pct    = bat ? gauge : -8'sd1;
         if (now - last_push >= 32'(history_iv)) begin
            last_push           = now;
            volt_ring[ring_pos] = held_mv;
            ring_pos            = (ring_pos + 1) % HISTORY_DEPTH;
            if (ring_fill < HISTORY_DEPTH) ring_fill++;
         end
         if (!bat) next_state = MON_UNKNOWN;
         else if (vbus) begin
            if (chg) next_state = MON_CHARGING;
            else if (held_mv >= full_mv_th || int'(held_pct) >= int'(full_pct_th))
               next_state = MON_FULL;
            else next_state = MON_USB;
         end else if (held_mv <= critical_mv_th) next_state = MON_CRITICAL;
         else if (held_mv <= low_mv_th) next_state = MON_LOW;
         else next_state = MON_BATTERY;
         if (next_state != cur_state) begin
            rep.state_changed = 1'b1;
            if (next_state == MON_CHARGING) begin
               charge_tracked = 1'b1;
               charge_t0      = now;
               charge_mv0     = held_mv;
            end else if (next_state != MON_FULL) begin
               charge_tracked = 1'b0;
            end
            cur_state = next_state;
         end
      end
      rep.state_code = cur_state;
      rep.battery_mv = held_mv;
      rep.percent    = shown_percent();
      if (ring_fill >= HISTORY_DEPTH) begin
         trend_v   = (int'(held_mv) - int'(volt_ring[ring_pos])) / 10;
         rep.trend = trend_v[10:0];
      end
      if (charge_tracked) begin
         since_v      = int'(held_mv) - int'(charge_mv0);
         rep.since_mv = since_v[13:0];
         elapsed      = now - charge_t0;
         rep.minutes  = 17'(elapsed / 60000);
      end
   endtask

   always @(posedge clock) begin : track
      poll_report_type fresh;
      poll_report_type seen;
      poll_report_type want;
      if (reset) begin
         clear_model();
         awaited_reports.delete();
      end else begin
         if (csr_we) take_csr(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            predict_poll(req_now_ms, req_battery_present, req_batt_mv, req_gauge_pct,
                         req_vbus_present, req_is_charging, fresh);
            awaited_reports.push_back(fresh);
         end
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_sampled, rsp_state_code, rsp_state_changed, rsp_battery_mv,
                    rsp_percent, rsp_trend_mv_per_min, rsp_since_charge_mv,
                    rsp_charge_minutes};
            if (awaited_reports.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: result item with no poll outstanding", $time);
               error_count++;
            end else begin
               want = awaited_reports.pop_front();
               if (seen !== want) begin
                  if (error_count < 10) begin
                     $display("%0t: result mismatch", $time);
                     $display("  expected smp=%b st=%0d chg=%b mv=%0d pct=%0d trend=%0d since=%0d min=%0d",
                              want.sampled, want.state_code, want.state_changed,
                              want.battery_mv, want.percent, want.trend, want.since_mv,
                              want.minutes);
                     $display("  actual   smp=%b st=%0d chg=%b mv=%0d pct=%0d trend=%0d since=%0d min=%0d",
                              seen.sampled, seen.state_code, seen.state_changed,
                              seen.battery_mv, seen.percent, seen.trend, seen.since_mv,
                              seen.minutes);
                  end
                  error_count++;
               end
            end
         end
      end
      reports_pending = awaited_reports.size();
   end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Battery status monitor testbench
// Drives polls through the monitor core with random idle and stall cycles,
// reprograms the thresholds and intervals between phases, and takes the
// verdict from the poll checker that sits beside the core.
// ----------------------------------------------------------------------------
module tb;
   import bsm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic signed [7:0]    GAUGE_NOT_READY = -8'sd1;
   localparam int                   STALL_LIMIT = 1000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [TIME_W-1:0]     req_now_ms;
   logic                  req_battery_present;
   logic [MV_W-1:0]       req_batt_mv;
   logic signed [PCT_W-1:0] req_gauge_pct;
   logic                  req_vbus_present;
   logic                  req_is_charging;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_sampled;
   logic [2:0]            rsp_state_code;
   logic                  rsp_state_changed;
   logic [12:0]           rsp_battery_mv;
   logic [6:0]            rsp_percent;
   logic signed [10:0]    rsp_trend_mv_per_min;
   logic signed [13:0]    rsp_since_charge_mv;
   logic [16:0]           rsp_charge_minutes;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int          error_count;
   int          reports_pending;
   int          quiet_cycles;
   logic        calm;
   time_type    poll_ms;
   int unsigned reg_shadow [7];

   battery_status_monitor_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_now_ms           (req_now_ms),
      .req_battery_present  (req_battery_present),
      .req_batt_mv          (req_batt_mv),
      .req_gauge_pct        (req_gauge_pct),
      .req_vbus_present     (req_vbus_present),
      .req_is_charging      (req_is_charging),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sampled          (rsp_sampled),
      .rsp_state_code       (rsp_state_code),
      .rsp_state_changed    (rsp_state_changed),
      .rsp_battery_mv       (rsp_battery_mv),
      .rsp_percent          (rsp_percent),
      .rsp_trend_mv_per_min (rsp_trend_mv_per_min),
      .rsp_since_charge_mv  (rsp_since_charge_mv),
      .rsp_charge_minutes   (rsp_charge_minutes),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   bsm_poll_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_now_ms           (req_now_ms),
      .req_battery_present  (req_battery_present),
      .req_batt_mv          (req_batt_mv),
      .req_gauge_pct        (req_gauge_pct),
      .req_vbus_present     (req_vbus_present),
      .req_is_charging      (req_is_charging),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_sampled          (rsp_sampled),
      .rsp_state_code       (rsp_state_code),
      .rsp_state_changed    (rsp_state_changed),
      .rsp_battery_mv       (rsp_battery_mv),
      .rsp_percent          (rsp_percent),
      .rsp_trend_mv_per_min (rsp_trend_mv_per_min),
      .rsp_since_charge_mv  (rsp_since_charge_mv),
      .rsp_charge_minutes   (rsp_charge_minutes),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .error_count          (error_count),
      .reports_pending      (reports_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready = calm ? 1'b1 : ($urandom_range(99) >= 25);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_poll(input time_type now, input logic bat, input mv_type mv,
                            input logic signed [7:0] gauge, input logic vbus,
                            input logic chg);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 15) gap = $urandom_range(3, 1);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           = 1'b1;
      req_now_ms          = now;
      req_battery_present = bat;
      req_batt_mv         = mv;
      req_gauge_pct       = gauge;
      req_vbus_present    = vbus;
      req_is_charging     = chg;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx != CSR_SPARE) reg_shadow[idx] = 32'(val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   function automatic mv_type pick_mv();
      int base;
      int r;
      r = $urandom_range(5);
      if (r >= 4) return mv_type'($urandom_range(8191));
      case (r)
         0: base = int'(reg_shadow[CSR_CRITICAL_MV] & 32'h1FFF);
         1: base = int'(reg_shadow[CSR_LOW_MV] & 32'h1FFF);
         2: base = int'(reg_shadow[CSR_FULL_MV] & 32'h1FFF);
         default: base = int'(reg_shadow[CSR_FALLBACK_MV] & 32'h1FFF)
                         + int'($urandom_range(1000));
      endcase
      base = base + int'($urandom_range(60)) - 30;
      if (base < 0) base = 0;
      if (base > 8191) base = 8191;
      return mv_type'(base);
   endfunction

   function automatic logic signed [7:0] pick_gauge();
      int r;
      int v;
      r = $urandom_range(9);
      if (r < 2) return GAUGE_NOT_READY;
      if (r < 3) return 8'($urandom_range(255));
      if (r < 6) return 8'($urandom_range(127));
      v = int'(reg_shadow[CSR_FULL_PCT] & 32'h7F) + int'($urandom_range(6)) - 3;
      return 8'(v);
   endfunction

   task automatic random_polls(input int count);
      int          mode;
      int          run_left;
      int          r;
      int unsigned s_iv;
      int unsigned step;
      logic        bat;
      logic        vbus;
      logic        chg;
      run_left = 0;
      mode     = 0;
      for (int k = 0; k < count; k++) begin
         if (run_left == 0) begin
            mode     = $urandom_range(9);
            run_left = $urandom_range(20, 2);
         end
         run_left--;
         s_iv = reg_shadow[CSR_SAMPLE_INTERVAL] & 32'hFFFF;
         r    = $urandom_range(99);
         if (r < 60) step = s_iv + $urandom_range(s_iv / 2 + 3);
         else if (r < 85) step = (s_iv == 0) ? 0 : $urandom_range(s_iv - 1);
         else if (r < 95) step = $urandom_range(200000);
         else step = $urandom;
         poll_ms = poll_ms + step;
         bat  = 1'b1;
         vbus = 1'b0;
         chg  = 1'b0;
         case (mode)
            0, 1, 2: ;
            3, 4, 5: begin
               vbus = 1'b1;
               chg  = 1'b1;
            end
            6, 7: vbus = 1'b1;
            8: begin
               bat  = 1'b0;
               vbus = 1'($urandom_range(1));
               chg  = 1'($urandom_range(1));
            end
            default: begin
               bat  = 1'($urandom_range(1));
               vbus = 1'($urandom_range(1));
               chg  = 1'($urandom_range(1));
            end
         endcase
         if ($urandom_range(9) == 0) begin
            vbus = 1'($urandom_range(1));
            chg  = 1'($urandom_range(1));
         end
         send_poll(poll_ms, bat, pick_mv(), pick_gauge(), vbus, chg);
      end
   endtask

   initial begin
      reset               = 1'b1;
      calm                = 1'b0;
      req_valid           = 1'b0;
      req_now_ms          = '0;
      req_battery_present = 1'b0;
      req_batt_mv         = '0;
      req_gauge_pct       = '0;
      req_vbus_present    = 1'b0;
      req_is_charging     = 1'b0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      poll_ms             = '0;
      reg_shadow[CSR_SAMPLE_INTERVAL]  = 32'(RST_SAMPLE_INTERVAL);
      reg_shadow[CSR_HISTORY_INTERVAL] = 32'(RST_HISTORY_INTERVAL);
      reg_shadow[CSR_FULL_MV]          = 32'(RST_FULL_MV);
      reg_shadow[CSR_FULL_PCT]         = 32'(RST_FULL_PCT);
      reg_shadow[CSR_CRITICAL_MV]      = 32'(RST_CRITICAL_MV);
      reg_shadow[CSR_LOW_MV]           = 32'(RST_LOW_MV);
      reg_shadow[CSR_FALLBACK_MV]      = 32'(RST_FALLBACK_MV);
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset settings: no-sample, no-battery, thresholds, charge record, wrap
      send_poll(32'd0,      1'b1, 13'd4000, 8'sd50,          1'b0, 1'b0);
      send_poll(32'd1999,   1'b1, 13'd4000, 8'sd50,          1'b0, 1'b0);
      send_poll(32'd2000,   1'b0, 13'd4000, 8'sd50,          1'b1, 1'b1);
      send_poll(32'd4000,   1'b1, 13'd8191, 8'sd127,         1'b0, 1'b0);
      send_poll(32'd6000,   1'b1, 13'd3300, GAUGE_NOT_READY, 1'b0, 1'b0);
      send_poll(32'd8000,   1'b1, 13'd3301, 8'sh80,          1'b0, 1'b0);
      send_poll(32'd10000,  1'b1, 13'd3500, GAUGE_NOT_READY, 1'b0, 1'b0);
      send_poll(32'd12000,  1'b1, 13'd4200, GAUGE_NOT_READY, 1'b1, 1'b1);
      send_poll(32'd14000,  1'b1, 13'd8191, GAUGE_NOT_READY, 1'b1, 1'b1);
      send_poll(32'd134000, 1'b1, 13'd4150, 8'sd98,          1'b1, 1'b0);
      send_poll(32'd136000, 1'b1, 13'd4000, 8'sd99,          1'b1, 1'b0);
      send_poll(32'd138000, 1'b1, 13'd4000, 8'sd98,          1'b1, 1'b0);
      send_poll(32'd140000, 1'b1, 13'd4000, GAUGE_NOT_READY, 1'b1, 1'b0);
      send_poll(32'd142000, 1'b1, 13'd0,    8'sd0,           1'b0, 1'b0);
      send_poll(32'd142001, 1'b1, 13'd5000, 8'sd70,          1'b1, 1'b1);
      send_poll(32'd144000, 1'b0, 13'd4000, 8'sd70,          1'b1, 1'b1);
      send_poll(32'd146000, 1'b1, 13'd3900, 8'sd60,          1'b1, 1'b1);
      send_poll(32'd146500, 1'b1, 13'd3950, 8'sd60,          1'b1, 1'b1);
      send_poll(32'hFFFF_F000, 1'b1, 13'd4050, 8'sd90,       1'b1, 1'b1);
      send_poll(32'h0000_0900, 1'b1, 13'd4080, 8'sd95,       1'b1, 1'b1);
      send_poll(32'hFFFF_FFFF, 1'b1, 13'd4099, 8'sd100,      1'b1, 1'b0);
      poll_ms = 32'hFFFF_FFFF;

      settle();
      write_reg(CSR_SAMPLE_INTERVAL,  20'($urandom_range(20)));
      write_reg(CSR_HISTORY_INTERVAL, 20'($urandom_range(40)));
      write_reg(CSR_FULL_MV,          20'($urandom_range(4150, 4050)));
      write_reg(CSR_FULL_PCT,         20'($urandom_range(100, 90)));
      write_reg(CSR_CRITICAL_MV,      20'($urandom_range(3350, 3250)));
      write_reg(CSR_LOW_MV,           20'($urandom_range(3550, 3450)));
      write_reg(CSR_FALLBACK_MV,      20'($urandom_range(3350, 3250)));
      write_reg(CSR_SPARE,            20'($urandom));
      random_polls(400);

      settle();
      calm = 1'b1;
      write_reg(CSR_SAMPLE_INTERVAL,  20'd0);
      write_reg(CSR_HISTORY_INTERVAL, 20'd0);
      write_reg(CSR_FULL_MV,          20'h1FFFF);
      write_reg(CSR_FULL_PCT,         20'hFFFFF);
      write_reg(CSR_CRITICAL_MV,      20'd0);
      write_reg(CSR_LOW_MV,           20'd8191);
      write_reg(CSR_FALLBACK_MV,      20'hFFFFF);
      random_polls(250);

      settle();
      calm = 1'b0;
      write_reg(CSR_SAMPLE_INTERVAL,  20'hFFFFF);
      write_reg(CSR_HISTORY_INTERVAL, 20'hFFFFF);
      write_reg(CSR_FULL_MV,          20'd0);
      write_reg(CSR_FULL_PCT,         20'd0);
      write_reg(CSR_CRITICAL_MV,      20'd8191);
      write_reg(CSR_LOW_MV,           20'd0);
      write_reg(CSR_FALLBACK_MV,      20'd0);
      random_polls(200);

      settle();
      write_reg(CSR_SAMPLE_INTERVAL,  20'($urandom_range(3000)));
      write_reg(CSR_HISTORY_INTERVAL, 20'($urandom_range(60000)));
      write_reg(CSR_FULL_MV,          20'($urandom));
      write_reg(CSR_FULL_PCT,         20'($urandom_range(127)));
      write_reg(CSR_CRITICAL_MV,      20'($urandom_range(3600, 3000)));
      write_reg(CSR_LOW_MV,           20'($urandom_range(3900, 3300)));
      write_reg(CSR_FALLBACK_MV,      20'($urandom));
      write_reg(CSR_SPARE,            20'hFFFFF);
      random_polls(350);

      req_valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
